// ===== hw/rtl/ltp_pkg.sv =====
// shared types, constants and functions of the lottery ticket picker
`default_nettype none
package ltp_pkg;

	localparam int SLOT_W = 6;
	localparam int TIX_W  = 16;
	localparam int SEED_W = 32;
	localparam int ALU_W  = SEED_W + 1;

	localparam logic [SEED_W-1:0] SEED_RESET = 32'd2463534242;

	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic [ALU_W-1:0] value;
		logic             borrow;
	} alu_res_t;

	function automatic logic [SEED_W-1:0] xs32(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] t;
		t = s ^ (s << XS_A);
		t = t ^ (t >> XS_B);
		t = t ^ (t << XS_C);
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ltp_alu.sv =====
// shared add / subtract unit used by the sum, modulo and walk steps
`default_nettype none
module ltp_alu (
	input  wire logic                      op,
	input  wire logic [ltp_pkg::ALU_W-1:0] a,
	input  wire logic [ltp_pkg::ALU_W-1:0] b,
	output ltp_pkg::alu_res_t              res
);

	logic [ltp_pkg::ALU_W:0] full;

	always_comb begin
		if (op == ltp_pkg::ALU_SUB) begin
			full = {1'b0, a} - {1'b0, b};
		end else begin
			full = {1'b0, a} + {1'b0, b};
		end
		res.value  = full[ltp_pkg::ALU_W-1:0];
		res.borrow = (op == ltp_pkg::ALU_SUB) && full[ltp_pkg::ALU_W];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ltp_table.sv =====
// slot table: runnable flags in flops, ticket counts in a memory with registered read
`default_nettype none
module ltp_table #(
	parameter int SLOT_COUNT = 64,
	parameter int IDX_W      = 6
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [IDX_W-1:0]          wr_addr,
	input  wire logic                      wr_run,
	input  wire logic [ltp_pkg::TIX_W-1:0] wr_tix,
	input  wire logic [IDX_W-1:0]          rd_addr,
	output logic                           rd_run,
	output logic [ltp_pkg::TIX_W-1:0]      rd_tix
);

	logic [SLOT_COUNT-1:0]     run_q;
	logic [ltp_pkg::TIX_W-1:0] tix_mem [SLOT_COUNT];

	// runnable flags clear at reset; a ticket entry is only read behind a set flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			rd_run <= 1'b0;
		end else begin
			if (wr_en) begin
				run_q[wr_addr] <= wr_run;
			end
			rd_run <= run_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tix_mem[wr_addr] <= wr_tix;
		end
		rd_tix <= tix_mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lottery_ticket_picker.sv =====
// lottery ticket picker: slot table, xorshift seed and a pick sequencer around one add/sub unit
// an update request is written straight into the slot table and gives no result; busy stays low
// a pick request runs one pass over the ticket memory for the sum, a seed step, 32 restoring-division
//   steps and a walk pass that stops at the winner; an empty sum ends it after the first pass
// throughput is one pick at a time, set by the single memory read port and the shared unit
// done pulses for one cycle with found and picked_slot; the receiver cannot stall
// async reset clears all runnable flags and loads the seed; ticket entries need no clear
`default_nettype none
module lottery_ticket_picker #(
	parameter int SLOT_COUNT = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              func,
	input  wire logic [ltp_pkg::SLOT_W-1:0]        slot,
	input  wire logic                              runnable,
	input  wire logic [ltp_pkg::TIX_W-1:0]         ticket_count,
	output logic                                   done,
	output logic                                   found,
	output logic [ltp_pkg::SLOT_W-1:0]             picked_slot
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_SEED = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;

	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

	logic [2:0]                    state_q;
	logic [ltp_pkg::SEED_W-1:0]    seed_q;
	logic [ltp_pkg::SEED_W-1:0]    total_q;
	logic [ltp_pkg::ALU_W-1:0]     rem_q;
	logic [4:0]                    bit_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              rd_idx_s1;
	logic                          done_q;
	logic                          found_q;
	logic [ltp_pkg::SLOT_W-1:0]    picked_q;

	logic                          accept;
	logic                          upd_en;
	logic                          issue;
	logic                          pick_end;
	logic                          rd_run;
	logic [ltp_pkg::TIX_W-1:0]     rd_tix;
	logic [ltp_pkg::TIX_W-1:0]     weight;
	logic                          alu_op;
	logic [ltp_pkg::ALU_W-1:0]     alu_a;
	logic [ltp_pkg::ALU_W-1:0]     alu_b;
	ltp_pkg::alu_res_t             alu_res;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	// updates beyond the table are dropped
	assign upd_en      = accept && !func && (32'(slot) < 32'(SLOT_COUNT));
	// slot counter of the sum or walk pass still has slots to read
	assign issue       = (cnt_q != CNT_END);
	// zero tickets weigh one
	assign weight      = (rd_tix == '0) ? ltp_pkg::TIX_W'(1) : rd_tix;
	// pick finishes: empty sum, winner found, or walk ran out of slots
	assign pick_end    = ((state_q == ST_SUM) && !issue && !rd_vld_s1 && (total_q == '0))
		|| ((state_q == ST_WALK)
			&& ((rd_vld_s1 && rd_run && alu_res.borrow) || (!issue && !rd_vld_s1)));
	assign done        = done_q;
	assign found       = found_q;
	assign picked_slot = picked_q;

	ltp_table #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (upd_en),
		.wr_addr(IDX_W'(slot)),
		.wr_run (runnable),
		.wr_tix (ticket_count),
		.rd_addr(cnt_q[IDX_W-1:0]),
		.rd_run (rd_run),
		.rd_tix (rd_tix)
	);

	// operand selection for the shared unit
	always_comb begin
		alu_op = ltp_pkg::ALU_SUB;
		alu_a  = rem_q;
		alu_b  = ltp_pkg::ALU_W'(weight);
		case (state_q)
			ST_SUM: begin
				// running sum of weights
				alu_op = ltp_pkg::ALU_ADD;
				alu_a  = ltp_pkg::ALU_W'(total_q);
			end
			ST_DIV: begin
				// restoring division step: shift in next seed bit, try subtracting the sum
				alu_a = {rem_q[ltp_pkg::SEED_W-1:0], seed_q[bit_q]};
				alu_b = ltp_pkg::ALU_W'(total_q);
			end
			default: begin
				// walk: draw minus slot weight, borrow marks the winner
				alu_op = ltp_pkg::ALU_SUB;
			end
		endcase
	end

	ltp_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seed_q    <= ltp_pkg::SEED_RESET;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= pick_end;
			case (state_q)
				ST_IDLE: begin
					if (accept && func) begin
						state_q   <= ST_SUM;
						cnt_q     <= '0;
						rd_vld_s1 <= 1'b0;
					end
				end
				ST_SUM: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (!issue && !rd_vld_s1) begin
						// pipe drained, sum final
						if (total_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SEED;
						end
					end
				end
				ST_SEED: begin
					seed_q  <= ltp_pkg::xs32(seed_q);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == 5'd0) begin
						state_q   <= ST_WALK;
						cnt_q     <= '0;
						rd_vld_s1 <= 1'b0;
					end
				end
				ST_WALK: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (rd_vld_s1 && rd_run && alu_res.borrow) begin
						state_q <= ST_IDLE;
					end else if (!issue && !rd_vld_s1) begin
						// no winner, cannot occur with a consistent draw
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				total_q <= '0;
			end
			ST_SUM: begin
				if (rd_vld_s1 && rd_run) begin
					total_q <= alu_res.value[ltp_pkg::SEED_W-1:0];
				end
				if (!issue && !rd_vld_s1) begin
					found_q  <= 1'b0;
					picked_q <= '0;
				end
			end
			ST_SEED: begin
				rem_q <= '0;
				bit_q <= 5'd31;
			end
			ST_DIV: begin
				rem_q <= alu_res.borrow ? alu_a : alu_res.value;
				bit_q <= bit_q - 5'd1;
			end
			ST_WALK: begin
				if (rd_vld_s1 && rd_run) begin
					if (alu_res.borrow) begin
						found_q  <= 1'b1;
						picked_q <= ltp_pkg::SLOT_W'(rd_idx_s1);
					end else begin
						rem_q <= alu_res.value;
					end
				end else if (!issue && !rd_vld_s1) begin
					found_q  <= 1'b0;
					picked_q <= '0;
				end
			end
			default: begin
				total_q <= total_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== verif/ltp_tb_pkg.sv =====
// request codes and result record shared by the picker testbench files
`timescale 1ns / 100ps
package ltp_tb_pkg;

	typedef enum logic {
		FUNC_UPDATE = 1'b0,
		FUNC_PICK   = 1'b1
	} req_func_e;

	typedef struct packed {
		logic                       found;
		logic [ltp_pkg::SLOT_W-1:0] slot;
	} pick_result_t;

endpackage

// ===== verif/ltp_checker.sv =====
// scoreboard for the lottery ticket picker: slot table and seed model, result comparison
`timescale 1ns / 100ps
module ltp_checker #(
	parameter int SLOT_COUNT = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic                       func,
	input  wire logic [ltp_pkg::SLOT_W-1:0] slot,
	input  wire logic                       runnable,
	input  wire logic [ltp_pkg::TIX_W-1:0]  ticket_count,
	input  wire logic                       done,
	input  wire logic                       found,
	input  wire logic [ltp_pkg::SLOT_W-1:0] picked_slot,
	output int                              fail_count,
	output int                              pending,
	output int                              checked,
	output int                              empty_picks
);
	import ltp_pkg::*;
	import ltp_tb_pkg::*;

	logic              ready_tbl [SLOT_COUNT];
	logic [TIX_W-1:0]  tix_tbl   [SLOT_COUNT];
	logic [SEED_W-1:0] seed_mdl;
	pick_result_t      winner_q  [$];

	// zero tickets still weigh one
	function automatic logic [31:0] slot_weight(int i);
		return (tix_tbl[i] == '0) ? 32'd1 : 32'(tix_tbl[i]);
	endfunction

	function automatic pick_result_t draw_winner();
		pick_result_t res;
		logic [31:0]  total;
		logic [31:0]  draw;
		res.found = 1'b0;
		res.slot  = '0;
		total     = '0;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (ready_tbl[i])
				total += slot_weight(i);
		// nothing runnable: seed stays put
		if (total == '0)
			return res;
		seed_mdl = seed_mdl ^ (seed_mdl << XS_A);
		seed_mdl = seed_mdl ^ (seed_mdl >> XS_B);
		seed_mdl = seed_mdl ^ (seed_mdl << XS_C);
		draw = seed_mdl % total;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (ready_tbl[i]) begin
				if (draw < slot_weight(i)) begin
					res.found = 1'b1;
					res.slot  = SLOT_W'(i);
					return res;
				end
				draw -= slot_weight(i);
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pick_result_t got;
		pick_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				ready_tbl[i] = 1'b0;
				tix_tbl[i]   = '0;
			end
			seed_mdl = SEED_RESET;
			winner_q.delete();
			fail_count  = 0;
			pending     = 0;
			checked     = 0;
			empty_picks = 0;
		end else begin
			// result of an earlier pick first, then the request taken at this edge
			if (done) begin
				got.found = found;
				got.slot  = picked_slot;
				if (winner_q.size() == 0) begin
					$error("result with no pick outstanding: found=%0d picked_slot=%0d",
						got.found, got.slot);
					fail_count++;
				end else begin
					want = winner_q.pop_front();
					checked++;
					if (got.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, got.found);
						fail_count++;
					end
					if (got.slot !== want.slot) begin
						$error("picked_slot: expected %0d, actual %0d", want.slot, got.slot);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				if (func == FUNC_PICK) begin
					want = draw_winner();
					if (!want.found)
						empty_picks++;
					winner_q.push_back(want);
				end else if (slot < SLOT_COUNT) begin
					ready_tbl[slot] = runnable;
					tix_tbl[slot]   = ticket_count;
				end
			end
			pending = winner_q.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// top of the lottery ticket picker testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
	import ltp_pkg::*;
	import ltp_tb_pkg::*;

	localparam int SLOTS        = 64;
	localparam int ITEM_TARGET  = 2000;
	// this limit outlasts the longest pick and the sender's long gaps,
	// so a quiet stretch of this length means the block is stuck
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 200;
	// sender never idles while this window of requests goes out
	localparam int BURST_FIRST  = 900;
	localparam int BURST_LAST   = 1300;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             func;
	logic [SLOT_W-1:0] slot;
	logic             runnable;
	logic [TIX_W-1:0] ticket_count;
	logic             done;
	logic             found;
	logic [SLOT_W-1:0] picked_slot;

	int fail_count;
	int pending;
	int checked;
	int empty_picks;

	int n_sent;
	int n_updates;
	int n_picks;
	int stall_cycles;

	lottery_ticket_picker #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.runnable    (runnable),
		.ticket_count(ticket_count),
		.done        (done),
		.found       (found),
		.picked_slot (picked_slot)
	);

	ltp_checker #(
		.SLOT_COUNT(SLOTS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.runnable    (runnable),
		.ticket_count(ticket_count),
		.done        (done),
		.found       (found),
		.picked_slot (picked_slot),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.empty_picks (empty_picks)
	);

	always #5 clk = ~clk;

	// ticket counts lean on zero, one-ish values and the maximum
	function automatic logic [TIX_W-1:0] ticket_value();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		else if (r < 25)
			return '1;
		else if (r < 55)
			return TIX_W'($urandom_range(1, 16));
		else
			return TIX_W'($urandom);
	endfunction

	// one request: optional idle cycles, then hold start until the block takes it
	task automatic issue_request(input req_func_e f, input logic [SLOT_W-1:0] s,
		input logic r, input logic [TIX_W-1:0] t);
		if (n_sent < BURST_FIRST || n_sent >= BURST_LAST) begin
			// short random gaps, and now and then a long one so the next
			// request lands somewhere inside a running pick
			while ($urandom_range(99) < 32) begin
				@(negedge clk);
				start <= 1'b0;
			end
			if ($urandom_range(99) < 3) begin
				repeat ($urandom_range(1, 180)) begin
					@(negedge clk);
					start <= 1'b0;
				end
			end
		end
		@(negedge clk);
		start        <= 1'b1;
		func         <= f;
		slot         <= s;
		runnable     <= r;
		ticket_count <= t;
		do
			@(posedge clk);
		while (!(start && !busy));
		n_sent++;
		if (f == FUNC_PICK)
			n_picks++;
		else
			n_updates++;
	endtask

	// a pick carries random slot fields, which the block must ignore
	task automatic issue_pick();
		issue_request(FUNC_PICK, SLOT_W'($urandom), 1'($urandom), TIX_W'($urandom));
	endtask

	// nothing taken for too long: the block has hung
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[lottery_ticket_picker] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int mode;
		int run_pct;
		int phase_len;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = FUNC_UPDATE;
		slot         = '0;
		runnable     = 1'b0;
		ticket_count = '0;
		n_sent       = 0;
		n_updates    = 0;
		n_picks      = 0;
		stall_cycles = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table right after reset, seed must not move
		issue_pick();
		// single runnable slot with zero tickets still wins
		issue_request(FUNC_UPDATE, 6'd0, 1'b1, 16'h0000);
		issue_pick();
		// top slot with the most tickets beside a weight-one slot
		issue_request(FUNC_UPDATE, 6'd63, 1'b1, 16'hFFFF);
		issue_pick();
		issue_pick();
		// slot 0 parked with tickets but not runnable
		issue_request(FUNC_UPDATE, 6'd0, 1'b0, 16'hFFFF);
		issue_pick();
		// back to nothing runnable after picks moved the seed
		issue_request(FUNC_UPDATE, 6'd63, 1'b0, 16'h0000);
		issue_pick();
		// a few neighbors with very different weights
		issue_request(FUNC_UPDATE, 6'd31, 1'b1, 16'h0001);
		issue_request(FUNC_UPDATE, 6'd32, 1'b1, 16'h0000);
		issue_request(FUNC_UPDATE, 6'd33, 1'b1, 16'h8000);
		issue_request(FUNC_UPDATE, 6'd1, 1'b1, 16'h7FFF);
		issue_pick();
		issue_pick();
		issue_pick();
		// rewrite the heaviest entry in place with a light count, then drop the other heavy one
		issue_request(FUNC_UPDATE, 6'd33, 1'b1, 16'h0002);
		issue_request(FUNC_UPDATE, 6'd1, 1'b0, 16'h5555);
		issue_pick();
		issue_request(FUNC_UPDATE, 6'd42, 1'b1, 16'hAAAA);
		issue_pick();

		// random: table-building phases with picks mixed in
		while (n_sent < ITEM_TARGET) begin
			mode = $urandom_range(19);
			if (mode == 0) begin
				// clear every slot, then a pick that must find nothing
				for (int i = 0; i < SLOTS; i++)
					issue_request(FUNC_UPDATE, SLOT_W'(i), 1'b0, ticket_value());
				issue_pick();
			end else if (mode == 1) begin
				// everything runnable, mostly at the maximum count
				for (int i = 0; i < SLOTS; i++)
					issue_request(FUNC_UPDATE, SLOT_W'(i), 1'b1,
						($urandom_range(1) != 0) ? 16'hFFFF : ticket_value());
				repeat (4) issue_pick();
			end else begin
				case ($urandom_range(3))
					0: begin
						run_pct = 5;
					end
					1: begin
						run_pct = 30;
					end
					2: begin
						run_pct = 70;
					end
					default: begin
						run_pct = 95;
					end
				endcase
				phase_len = $urandom_range(20, 80);
				repeat (phase_len) begin
					if ($urandom_range(99) < 40)
						issue_pick();
					else
						issue_request(FUNC_UPDATE, SLOT_W'($urandom),
							($urandom_range(99) < run_pct), ticket_value());
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		// drain outstanding picks, then give stray results time to show up
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("sent %0d requests: %0d slot updates and %0d lottery picks",
			n_sent, n_updates, n_picks);
		$display("compared %0d pick results, %0d of them with no runnable slot",
			checked, empty_picks);
		if (fail_count == 0)
			$display("[lottery_ticket_picker] OK");
		else
			$display("[lottery_ticket_picker] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ltp_pkg.sv
hw/rtl/ltp_alu.sv
hw/rtl/ltp_table.sv
hw/rtl/lottery_ticket_picker.sv
verif/ltp_tb_pkg.sv
verif/ltp_checker.sv
verif/tb_top.sv
